// ===== design/spiral_matrix_reorder_top_defines.svh =====
// assertion macros for the spiral matrix reorder block
// used by spiral_matrix_reorder_top, expects clk and rst in scope
`ifndef SPIRAL_MATRIX_REORDER_TOP_DEFINES_SVH
`define SPIRAL_MATRIX_REORDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SMR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SMR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SMR_ASSERT_IMPL(name, ante, cons, msg)
`define SMR_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== design/smr_pkg.sv =====
// shared types, constants and helpers for the spiral matrix reorder block
// no dependencies
package smr_pkg;

  localparam int MAX_DIM = 8;
  localparam int DIM_W   = 3;
  localparam int SIZE_W  = 4;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int CNT_W   = 7;
  localparam int DATA_W  = 8;
  localparam int IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_NUM_COLS = 2'd0;
  localparam logic [IDX_W-1:0] REG_NUM_ROWS = 2'd1;
  localparam logic [IDX_W-1:0] REG_CCW      = 2'd2;

  // matrix shape handed to the walker at start
  typedef struct packed {
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic [CNT_W-1:0]  total;
    logic              ccw;
  } smr_dims_t;

  // current walker position
  typedef struct packed {
    logic             active;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;
  } smr_walk_t;

  // force a dimension into 1..MAX_DIM
  function automatic logic [SIZE_W-1:0] smr_clamp(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(MAX_DIM)) r = SIZE_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // element count of the matrix
  function automatic logic [CNT_W-1:0] smr_total(input logic [SIZE_W-1:0] c,
                                                 input logic [SIZE_W-1:0] r);
    logic [2*SIZE_W-1:0] p;
    p = c * r;
    return p[CNT_W-1:0];
  endfunction

endpackage

// ===== design/smr_store.sv =====
// element store: 64 x 8 synchronous ram, one write and one registered read port
// depends on smr_pkg
module smr_store
  import smr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [MAX_DIM*MAX_DIM];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/smr_walker.sv =====
// spiral address walker: one (row, col) per step in spiral order
// depends on smr_pkg
module smr_walker
  import smr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  smr_dims_t dims,
  input  logic      step,
  output smr_walk_t pos
);

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  logic             active;
  logic             ccw;
  logic [1:0]       dir;
  logic [DIM_W-1:0] row;
  logic [DIM_W-1:0] col;
  logic [DIM_W-1:0] top;
  logic [DIM_W-1:0] bottom;
  logic [DIM_W-1:0] left;
  logic [DIM_W-1:0] right;
  logic [CNT_W-1:0] remain;

  logic             at_end;
  logic [1:0]       dir_next;
  logic [1:0]       move_dir;
  logic [DIM_W-1:0] top_next;
  logic [DIM_W-1:0] bottom_next;
  logic [DIM_W-1:0] left_next;
  logic [DIM_W-1:0] right_next;
  logic [DIM_W-1:0] row_next;
  logic [DIM_W-1:0] col_next;

  // end of the current side
  always_comb begin
    unique case (dir)
      DIR_RIGHT: at_end = (col == right);
      DIR_DOWN:  at_end = (row == bottom);
      DIR_LEFT:  at_end = (col == left);
      DIR_UP:    at_end = (row == top);
      default:   at_end = 1'b0;
    endcase
  end

  // turn: next direction and the bound that moves inward
  always_comb begin
    top_next    = top;
    bottom_next = bottom;
    left_next   = left;
    right_next  = right;
    dir_next    = dir;
    unique case (dir)
      DIR_RIGHT: begin
        dir_next = ccw ? DIR_UP : DIR_DOWN;
        if (ccw) bottom_next = bottom - 1'b1;
        else top_next = top + 1'b1;
      end
      DIR_DOWN: begin
        dir_next = ccw ? DIR_RIGHT : DIR_LEFT;
        if (ccw) left_next = left + 1'b1;
        else right_next = right - 1'b1;
      end
      DIR_LEFT: begin
        dir_next = ccw ? DIR_DOWN : DIR_UP;
        if (ccw) top_next = top + 1'b1;
        else bottom_next = bottom - 1'b1;
      end
      DIR_UP: begin
        dir_next = ccw ? DIR_LEFT : DIR_RIGHT;
        if (ccw) right_next = right - 1'b1;
        else left_next = left + 1'b1;
      end
      default: dir_next = dir;
    endcase
  end

  // every new side starts one step from the corner in its own direction
  assign move_dir = at_end ? dir_next : dir;

  always_comb begin
    row_next = row;
    col_next = col;
    unique case (move_dir)
      DIR_RIGHT: col_next = col + 1'b1;
      DIR_DOWN:  row_next = row + 1'b1;
      DIR_LEFT:  col_next = col - 1'b1;
      DIR_UP:    row_next = row - 1'b1;
      default:   row_next = row;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (step && remain == CNT_W'(1)) begin
      active <= 1'b0;
    end
  end

  // position and bounds
  always_ff @(posedge clk) begin
    if (start) begin
      ccw    <= dims.ccw;
      dir    <= dims.ccw ? DIR_DOWN : DIR_RIGHT;
      row    <= '0;
      col    <= '0;
      top    <= '0;
      left   <= '0;
      right  <= DIM_W'(dims.cols - 1'b1);
      bottom <= DIM_W'(dims.rows - 1'b1);
      remain <= dims.total;
    end else if (step) begin
      remain <= remain - 1'b1;
      row    <= row_next;
      col    <= col_next;
      if (at_end) begin
        dir    <= dir_next;
        top    <= top_next;
        bottom <= bottom_next;
        left   <= left_next;
        right  <= right_next;
      end
    end
  end

  assign pos.active = active;
  assign pos.row    = row;
  assign pos.col    = col;
  assign pos.last   = (remain == CNT_W'(1));

endmodule

// ===== design/spiral_matrix_reorder_top.sv =====
// load: each input word is accepted in idle, then written to the store; a column-width change mid-load
//   first re-derives the load position by repeated subtraction of the column width
// emission: words pass the store read stage, then the output register; 1 word per cycle unless
//   out_ready stalls the output, paced by the single read port of the element store
// reset: synchronous, clears load count and handshakes; store contents stay undefined
// top level of the spiral matrix reorder block; depends on smr_pkg, smr_store, smr_walker
`include "spiral_matrix_reorder_top_defines.svh"

module spiral_matrix_reorder_top
  import smr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] element,
  output logic [DIM_W-1:0]  row_pos,
  output logic [DIM_W-1:0]  col_pos,
  output logic              last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state;
  logic [SIZE_W-1:0] num_cols;
  logic [SIZE_W-1:0] num_rows;
  logic              counter_clockwise;
  logic              cols_dirty;
  logic [CNT_W-1:0]  load_count;
  logic [DIM_W-1:0]  load_row;
  logic [DIM_W-1:0]  load_col;
  logic [CNT_W-1:0]  div_rem;
  logic [DATA_W-1:0] in_word;

  logic [SIZE_W-1:0] eff_cols;
  logic [SIZE_W-1:0] eff_rows;
  logic [CNT_W-1:0]  total;
  logic              restart;
  logic [DIM_W-1:0]  wr_row;
  logic [DIM_W-1:0]  wr_col;
  logic [CNT_W-1:0]  cnt_inc;
  logic              store_we;
  logic              walk_start;
  smr_dims_t         dims;
  smr_walk_t         walk;
  logic              rd_issue;
  logic [DATA_W-1:0] rdata;
  logic              p1_valid;
  logic              p1_move;
  logic [DIM_W-1:0]  p1_row;
  logic [DIM_W-1:0]  p1_col;
  logic              p1_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols          <= SIZE_W'(MAX_DIM);
      num_rows          <= SIZE_W'(MAX_DIM);
      counter_clockwise <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_COLS: num_cols <= cfg_data;
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_CCW:      counter_clockwise <= cfg_data[0];
        default:      num_cols <= num_cols;
      endcase
    end
  end

  // effective shape
  assign eff_cols = smr_clamp(num_cols);
  assign eff_rows = smr_clamp(num_rows);
  assign total    = smr_total(eff_cols, eff_rows);

  // load position, restarting when the count no longer fits the matrix
  assign restart  = (load_count >= total);
  assign wr_row   = restart ? '0 : load_row;
  assign wr_col   = restart ? '0 : load_col;
  assign cnt_inc  = (restart ? '0 : load_count) + 1'b1;
  assign store_we = (state == S_LOAD) && (restart || !cols_dirty);
  assign walk_start = store_we && (cnt_inc == total);

  assign in_ready = (state == S_IDLE);

  // load sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
      load_row   <= '0;
      load_col   <= '0;
      cols_dirty <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_NUM_COLS) begin
        cols_dirty <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!store_we) begin
            // column width changed: redo row and column from the count
            div_rem  <= load_count;
            load_row <= '0;
            state    <= S_DIV;
          end else begin
            cols_dirty <= 1'b0;
            if (walk_start) begin
              load_count <= '0;
              load_row   <= '0;
              load_col   <= '0;
              state      <= S_EMIT;
            end else begin
              load_count <= cnt_inc;
              if ({1'b0, wr_col} + 1'b1 == eff_cols) begin
                load_col <= '0;
                load_row <= wr_row + 1'b1;
              end else begin
                load_col <= wr_col + 1'b1;
                load_row <= wr_row;
              end
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          // one subtraction of the column width per cycle
          if (div_rem >= CNT_W'(eff_cols)) begin
            div_rem  <= div_rem - CNT_W'(eff_cols);
            load_row <= load_row + 1'b1;
          end else begin
            load_col   <= div_rem[DIM_W-1:0];
            cols_dirty <= 1'b0;
            state      <= S_LOAD;
          end
        end
        S_EMIT: begin
          if (!walk.active && !p1_valid) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input word holding register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word <= value;
    end
  end

  assign dims.cols  = eff_cols;
  assign dims.rows  = eff_rows;
  assign dims.total = total;
  assign dims.ccw   = counter_clockwise;

  smr_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .dims  (dims),
    .step  (rd_issue),
    .pos   (walk)
  );

  // read pipeline: store read stage, then output register
  assign p1_move  = p1_valid && (!out_valid || out_ready);
  assign rd_issue = walk.active && (!p1_valid || p1_move);

  smr_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr ({wr_row, wr_col}),
    .wdata (in_word),
    .re    (rd_issue),
    .raddr ({walk.row, walk.col}),
    .rdata (rdata)
  );

  // read stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (rd_issue) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      p1_row  <= walk.row;
      p1_col  <= walk.col;
      p1_last <= walk.last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      element <= rdata;
      row_pos <= p1_row;
      col_pos <= p1_col;
      last    <= p1_last;
    end
  end

  // checks
  `SMR_ASSERT_IMPL(a_no_load_during_walk, in_ready, !walk.active && !p1_valid, "input open in run")
  `SMR_ASSERT_IMPL(a_last_ends_walk, p1_valid && p1_last, !walk.active, "walk active after last")
  `SMR_ASSERT_NEXT(a_read_fills_stage, rd_issue, p1_valid, "store read lost")
  `SMR_ASSERT_IMPL(a_div_only_when_dirty, state == S_DIV, cols_dirty, "stray divide")

endmodule

// ===== bench/tb_spiral_matrix_reorder_top.sv =====
// self-checking testbench for spiral_matrix_reorder_top: loads matrices word by word and
// checks every spiral-order output word against an in-bench predictor
// depends on smr_pkg and the spiral_matrix_reorder_top rtl
module tb_spiral_matrix_reorder_top
  import smr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 72;   // well above store write plus worst-case divide
  localparam int TAIL_CYCLES   = 80;
  localparam int LONG_HOLD     = 200;
  localparam int STOP_WORDS    = 150;  // random loop ends here, last matrix runs a bit past
  localparam int CALM_WORDS    = 130;
  localparam int MAX_REPORTS   = 10;
  localparam int PLAN_LEN      = 40;

  // index past the last register, writes to it are dropped
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] element;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic              last;
  } spiral_word_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] data;
    logic [DATA_W-1:0] val;
    logic              typed;
    spiral_word_t      want;
  } plan_row_t;

  // walk direction legs, meaning depends on the rotation
  typedef enum logic [1:0] {LEG_FIRST, LEG_SECOND, LEG_THIRD, LEG_FOURTH} leg_e;

  // directed table: 1x1 rows carry their result, the rest go through the predictor
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{ROW_REG,  REG_NUM_COLS, 4'd1, 8'h00, 1'b0, '0},
    '{ROW_REG,  REG_NUM_ROWS, 4'd1, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h00, 1'b1, '{8'h00, 3'd0, 3'd0, 1'b1}},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'hFF, 1'b1, '{8'hFF, 3'd0, 3'd0, 1'b1}},
    // zero width counts as one
    '{ROW_REG,  REG_NUM_COLS, 4'd0, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'hA5, 1'b1, '{8'hA5, 3'd0, 3'd0, 1'b1}},
    // zero height counts as one
    '{ROW_REG,  REG_NUM_ROWS, 4'd0, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h5A, 1'b1, '{8'h5A, 3'd0, 3'd0, 1'b1}},
    // out-of-range register index leaves the shape alone
    '{ROW_REG,  REG_UNUSED,   4'hF, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h3C, 1'b1, '{8'h3C, 3'd0, 3'd0, 1'b1}},
    // 2x2 clockwise
    '{ROW_REG,  REG_NUM_COLS, 4'd2, 8'h00, 1'b0, '0},
    '{ROW_REG,  REG_NUM_ROWS, 4'd2, 8'h00, 1'b0, '0},
    '{ROW_REG,  REG_CCW,      4'd0, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h11, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h22, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h33, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h44, 1'b0, '0},
    // 2x2 counter-clockwise, upper data bits ignored
    '{ROW_REG,  REG_CCW,      4'hF, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h55, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h66, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h77, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h88, 1'b0, '0},
    // oversized width clamps to a full 8-wide row
    '{ROW_REG,  REG_NUM_COLS, 4'hF, 8'h00, 1'b0, '0},
    '{ROW_REG,  REG_NUM_ROWS, 4'd1, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h01, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h02, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h04, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h08, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h10, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h20, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h40, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h80, 1'b0, '0},
    // partial 2x2, then shrink to 1x1 so the load restarts
    '{ROW_REG,  REG_NUM_COLS, 4'd2, 8'h00, 1'b0, '0},
    '{ROW_REG,  REG_NUM_ROWS, 4'd2, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h9A, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'hBC, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'hDE, 1'b0, '0},
    '{ROW_REG,  REG_NUM_COLS, 4'd1, 8'h00, 1'b0, '0},
    '{ROW_REG,  REG_NUM_ROWS, 4'd1, 8'h00, 1'b0, '0},
    '{ROW_WORD, REG_NUM_COLS, 4'd0, 8'h77, 1'b1, '{8'h77, 3'd0, 3'd0, 1'b1}}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] value = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [DATA_W-1:0] element;
  logic [DIM_W-1:0]  row_pos;
  logic [DIM_W-1:0]  col_pos;
  logic              last;

  // predictor state
  logic [DATA_W-1:0] shadow_store [MAX_DIM*MAX_DIM];
  int                loaded;
  logic [SIZE_W-1:0] shape_cols;
  logic [SIZE_W-1:0] shape_rows;
  logic              shape_ccw;

  spiral_word_t      spiral_run[$];      // words of the run just predicted
  spiral_word_t      pending_spiral[$];  // words still owed by the block

  int   fail_count = 0;
  int   words_in = 0;
  int   gap_pct = 30;
  logic calm = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int   rx_hold_left = 0;

  spiral_matrix_reorder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .row_pos   (row_pos),
    .col_pos   (col_pos),
    .last      (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int fit_dim(input logic [SIZE_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic void take_cell(input int r, input int c);
    spiral_word_t w;
    w.element = shadow_store[(r * MAX_DIM + c) & (MAX_DIM * MAX_DIM - 1)];
    w.row     = DIM_W'(r);
    w.col     = DIM_W'(c);
    w.last    = 1'b0;
    spiral_run.push_back(w);
  endfunction

  // spiral read-out with shrinking bounds
  function automatic void walk_spiral(input int c, input int r, input logic ccw);
    int lft, top, rgt, bot, i;
    leg_e leg;
    spiral_word_t w;
    lft = 0;
    top = 0;
    rgt = c - 1;
    bot = r - 1;
    leg = LEG_FIRST;
    while (lft <= rgt && top <= bot) begin
      if (!ccw) begin
        case (leg)
          LEG_FIRST: begin
            for (i = lft; i <= rgt; i++) take_cell(top, i);
            top++;
          end
          LEG_SECOND: begin
            for (i = top; i <= bot; i++) take_cell(i, rgt);
            rgt--;
          end
          LEG_THIRD: begin
            for (i = rgt; i >= lft; i--) take_cell(bot, i);
            bot--;
          end
          default: begin
            for (i = bot; i >= top; i--) take_cell(i, lft);
            lft++;
          end
        endcase
      end else begin
        case (leg)
          LEG_FIRST: begin
            for (i = top; i <= bot; i++) take_cell(i, lft);
            lft++;
          end
          LEG_SECOND: begin
            for (i = lft; i <= rgt; i++) take_cell(bot, i);
            bot--;
          end
          LEG_THIRD: begin
            for (i = bot; i >= top; i--) take_cell(i, rgt);
            rgt--;
          end
          default: begin
            for (i = rgt; i >= lft; i--) take_cell(top, i);
            top++;
          end
        endcase
      end
      leg = leg_e'(leg + 2'd1);
    end
    if (spiral_run.size() > 0) begin
      w = spiral_run.pop_back();
      w.last = 1'b1;
      spiral_run.push_back(w);
    end
  endfunction

  // store one word in row-major order, read out the spiral when the matrix is full
  function automatic void load_and_walk(input logic [DATA_W-1:0] v);
    int c, r, total, at_row, at_col;
    c = fit_dim(shape_cols);
    r = fit_dim(shape_rows);
    total = c * r;
    spiral_run.delete();
    if (loaded >= total) loaded = 0;
    at_row = loaded / c;
    at_col = loaded % c;
    shadow_store[(at_row * MAX_DIM + at_col) & (MAX_DIM * MAX_DIM - 1)] = v;
    loaded = (loaded + 1) & 'h7F;
    if (loaded == total) begin
      loaded = 0;
      walk_spiral(c, r, shape_ccw);
    end
  endfunction

  function automatic logic [SIZE_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 60) return SIZE_W'($urandom_range(4, 1));
    if (r < 85) return SIZE_W'($urandom_range(8, 5));
    if (r < 92) return '0;
    return SIZE_W'($urandom_range(15, 9));
  endfunction

  // wait until the block has delivered everything and gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_spiral.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_COLS: shape_cols = data;
      REG_NUM_ROWS: shape_rows = data;
      REG_CCW:      shape_ccw = data[0];
      default: ;
    endcase
  endtask

  // offer one word, predict its results once it is taken
  task automatic send_word(input logic [DATA_W-1:0] v, input logic typed,
                           input spiral_word_t want);
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_in++;
    load_and_walk(v);
    if (typed) pending_spiral.push_back(want);
    else foreach (spiral_run[k]) pending_spiral.push_back(spiral_run[k]);
  endtask

  // random words until the current matrix completes
  task automatic finish_matrix();
    do send_word(DATA_W'($urandom), 1'b0, '0); while (loaded != 0);
  endtask

  // rewrite a random subset of the shape registers
  task automatic reshape();
    logic touched;
    touched = 1'b0;
    if ($urandom_range(99) < 70) begin
      write_reg(REG_NUM_COLS, pick_dim());
      touched = 1'b1;
    end
    if ($urandom_range(99) < 70) begin
      write_reg(REG_NUM_ROWS, pick_dim());
      touched = 1'b1;
    end
    if ($urandom_range(99) < 40) begin
      write_reg(REG_CCW, SIZE_W'($urandom));
      touched = 1'b1;
    end
    if ($urandom_range(99) < 10) write_reg(REG_UNUSED, SIZE_W'($urandom));
    if (!touched) write_reg(REG_NUM_COLS, pick_dim());
  endtask

  // output pacing: short random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready    <= 1'b1;
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      out_ready      <= 1'b0;
      rx_hold_left   <= LONG_HOLD - 1;
    end else if (!calm && $urandom_range(99) < 20) begin
      out_ready    <= 1'b0;
      rx_hold_left <= $urandom_range(3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each delivered word with the oldest prediction
  always @(posedge clk) begin : check_words
    spiral_word_t got, want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = '{element, row_pos, col_pos, last};
      if (pending_spiral.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected word: element %02h row %0d col %0d last %0b",
                   got.element, got.row, got.col, got.last);
        fail_count++;
      end else begin
        want = pending_spiral.pop_front();
        if (got !== want) begin
          if (fail_count < MAX_REPORTS)
            $display("mismatch: expected %02h row %0d col %0d last %0b, got %02h %0d %0d %0b",
                     want.element, want.row, want.col, want.last,
                     got.element, got.row, got.col, got.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int k;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    loaded     = 0;
    shape_cols = SIZE_W'(8);
    shape_rows = SIZE_W'(8);
    shape_ccw  = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_REG)
        write_reg(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].data);
      else
        send_word(DIRECTED_PLAN[i].val, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    // full 8x8 with oversized dimensions, fills every store entry
    write_reg(REG_NUM_COLS, 4'd9);
    write_reg(REG_NUM_ROWS, 4'hF);
    write_reg(REG_CCW, SIZE_W'($urandom));
    finish_matrix();

    // back-to-back 2x2 matrices against a long output hold-off
    write_reg(REG_NUM_COLS, 4'd2);
    write_reg(REG_NUM_ROWS, 4'd2);
    long_hold_req <= 1'b1;
    repeat (6) finish_matrix();

    // random matrices, some reshaped part way through the load
    while (words_in < STOP_WORDS) begin
      if (words_in >= CALM_WORDS) calm <= 1'b1;
      gap_pct = ($urandom_range(3) == 0) ? 0 : 30;
      if ($urandom_range(99) < 25 && fit_dim(shape_cols) * fit_dim(shape_rows) > 1) begin
        k = $urandom_range(fit_dim(shape_cols) * fit_dim(shape_rows) - 1, 1);
        repeat (k) send_word(DATA_W'($urandom), 1'b0, '0);
        reshape();
      end else if ($urandom_range(99) < 80) begin
        reshape();
      end
      finish_matrix();
    end

    // drain
    calm     <= 1'b1;
    in_valid <= 1'b0;
    while (pending_spiral.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_spiral.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
